>>> rtl/tun_pkg.sv
// tun_pkg: shared constants for the triangle unit normal pipeline.
// No dependencies.
`timescale 1ns / 1ps
package tun_pkg;
    localparam int RED_BITS  = 31;  // reduced component magnitude width
    localparam int SUM_BITS  = 64;  // sum of squares width
    localparam int ROOT_BITS = 32;  // integer square root width
endpackage

>>> rtl/tun_if.sv
// tun_in_if / tun_out_if: valid-ready channels for vertex and normal items.
// No dependencies.
`timescale 1ns / 1ps
interface tun_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z;
    logic signed [COORD_WIDTH-1:0] b_x, b_y, b_z;
    logic signed [COORD_WIDTH-1:0] c_x, c_y, c_z;
    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
    modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tun_out_if #(parameter int NORMAL_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [NORMAL_WIDTH-1:0] normal_x, normal_y, normal_z;
    logic                           degenerate;
    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

>>> rtl/tun_cross.sv
// tun_cross: edge vectors and exact cross product, three register stages.
// Depends on nothing but the clock enable from the top level.
`timescale 1ns / 1ps
module tun_cross #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [W-1:0]   i_a_x, i_a_y, i_a_z,
    input  logic signed [W-1:0]   i_b_x, i_b_y, i_b_z,
    input  logic signed [W-1:0]   i_c_x, i_c_y, i_c_z,
    output logic                  o_valid,
    output logic signed [2*W+1:0] o_n_x, o_n_y, o_n_z
);
    logic [2:0] r_v;
    logic signed [W:0]     r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [2*W+1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [2*W+1:0] r_nx, r_ny, r_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: edges, one bit wider than the coordinates
            r_e1x <= $signed({i_b_x[W-1], i_b_x}) - $signed({i_a_x[W-1], i_a_x});
            r_e1y <= $signed({i_b_y[W-1], i_b_y}) - $signed({i_a_y[W-1], i_a_y});
            r_e1z <= $signed({i_b_z[W-1], i_b_z}) - $signed({i_a_z[W-1], i_a_z});
            r_e2x <= $signed({i_c_x[W-1], i_c_x}) - $signed({i_a_x[W-1], i_a_x});
            r_e2y <= $signed({i_c_y[W-1], i_c_y}) - $signed({i_a_y[W-1], i_a_y});
            r_e2z <= $signed({i_c_z[W-1], i_c_z}) - $signed({i_a_z[W-1], i_a_z});
            // stage 2: six products
            r_p0 <= r_e1y * r_e2z;
            r_p1 <= r_e1z * r_e2y;
            r_p2 <= r_e1z * r_e2x;
            r_p3 <= r_e1x * r_e2z;
            r_p4 <= r_e1x * r_e2y;
            r_p5 <= r_e1y * r_e2x;
            // stage 3: differences, |N| < 2^(2W+1)
            r_nx <= r_p0 - r_p1;
            r_ny <= r_p2 - r_p3;
            r_nz <= r_p4 - r_p5;
        end
    end

    assign o_valid = r_v[2];
    assign o_n_x   = r_nx;
    assign o_n_y   = r_ny;
    assign o_n_z   = r_nz;
endmodule

>>> rtl/tun_reduce.sv
// tun_reduce: magnitudes, shift to 31 bits, squares and their sum; five stages.
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_reduce #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [2*W+1:0] i_n_x, i_n_y, i_n_z,
    output logic                  o_valid,
    output logic [tun_pkg::SUM_BITS-1:0]           o_sum,
    output logic [2:0][tun_pkg::RED_BITS-1:0]      o_m,
    output logic [2:0]                             o_neg,
    output logic                                   o_deg
);
    import tun_pkg::*;
    localparam int MW  = 2 * W + 1;
    localparam int SW  = $clog2(MW - RED_BITS + 1);
    localparam int SQW = 2 * RED_BITS;

    logic [4:0] r_v;
    logic [2:0][MW-1:0]       r_mag4, r_mag5;
    logic [2:0]               r_neg4, r_neg5, r_neg6, r_neg7, r_neg8;
    logic [MW-1:0]            r_or4;
    logic [SW-1:0]            r_s5, n_s;
    logic                     r_deg5, r_deg6, r_deg7, r_deg8;
    logic [2:0][RED_BITS-1:0] r_m6, r_m7, r_m8;
    logic [2:0][SQW-1:0]      r_sq7;
    logic [SUM_BITS-1:0]      r_sum8;
    logic [2:0][MW-1:0]       n_mag;
    logic [2:0][MW-1:0]       shifted;
    logic signed [2:0][2*W+1:0] n_in;

    assign n_in = {i_n_z, i_n_y, i_n_x};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = n_in[k][2*W+1] ? MW'(-n_in[k]) : MW'(n_in[k]);
        end
    end

    // the highest set bit of the OR is that of the largest magnitude
    always_comb begin
        n_s = '0;
        for (int i = RED_BITS; i < MW; i++) begin
            if (r_or4[i]) begin
                n_s = SW'(i - RED_BITS + 1);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            shifted[k] = r_mag5[k] >> r_s5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag4 <= n_mag;
            r_neg4 <= {i_n_z[2*W+1], i_n_y[2*W+1], i_n_x[2*W+1]};
            r_or4  <= n_mag[0] | n_mag[1] | n_mag[2];

            r_mag5 <= r_mag4;
            r_neg5 <= r_neg4;
            r_s5   <= n_s;
            r_deg5 <= (r_or4 == '0);

            for (int k = 0; k < 3; k++) begin
                r_m6[k]  <= shifted[k][RED_BITS-1:0];
                r_sq7[k] <= SQW'(r_m6[k]) * SQW'(r_m6[k]);
            end
            r_neg6 <= r_neg5;
            r_deg6 <= r_deg5;

            r_m7   <= r_m6;
            r_neg7 <= r_neg6;
            r_deg7 <= r_deg6;

            r_sum8 <= SUM_BITS'(r_sq7[0]) + SUM_BITS'(r_sq7[1]) + SUM_BITS'(r_sq7[2]);
            r_m8   <= r_m7;
            r_neg8 <= r_neg7;
            r_deg8 <= r_deg7;
        end
    end

    assign o_valid = r_v[4];
    assign o_sum   = r_sum8;
    assign o_m     = r_m8;
    assign o_neg   = r_neg8;
    assign o_deg   = r_deg8;
endmodule

>>> rtl/tun_sqrt.sv
// tun_sqrt: pipelined integer square root, one root bit per stage.
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_sqrt #(
    parameter int SBW = 98
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [tun_pkg::SUM_BITS-1:0]    i_x,
    input  logic [SBW-1:0]                  i_sb,
    output logic                            o_valid,
    output logic [tun_pkg::ROOT_BITS-1:0]   o_root,
    output logic [SBW-1:0]                  o_sb
);
    import tun_pkg::*;
    localparam int RW = ROOT_BITS + 4;

    logic [ROOT_BITS-1:0]                 r_v;
    logic [ROOT_BITS-1:0][RW-1:0]         r_rem;
    logic [ROOT_BITS-1:0][ROOT_BITS-1:0]  r_root;
    logic [ROOT_BITS-1:0][SUM_BITS-1:0]   r_x;
    logic [ROOT_BITS-1:0][SBW-1:0]        r_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ROOT_BITS-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        logic [RW-1:0]        rem_i, cur, trial;
        logic [ROOT_BITS-1:0] root_i;
        logic [SUM_BITS-1:0]  x_i;
        logic [SBW-1:0]       sb_i;
        logic                 ge;

        if (k == 0) begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign x_i    = i_x;
            assign sb_i   = i_sb;
        end else begin : g_next
            assign rem_i  = r_rem[k-1];
            assign root_i = r_root[k-1];
            assign x_i    = r_x[k-1];
            assign sb_i   = r_sb[k-1];
        end

        assign cur   = {rem_i[RW-3:0], x_i[SUM_BITS-1 -: 2]};
        assign trial = {{(RW-ROOT_BITS-2){1'b0}}, root_i, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? cur - trial : cur;
                r_root[k] <= {root_i[ROOT_BITS-2:0], ge};
                r_x[k]    <= {x_i[SUM_BITS-3:0], 2'b00};
                r_sb[k]   <= sb_i;
            end
        end
    end

    assign o_valid = r_v[ROOT_BITS-1];
    assign o_root  = r_root[ROOT_BITS-1];
    assign o_sb    = r_sb[ROOT_BITS-1];
endmodule

>>> rtl/tun_div.sv
// tun_div: three-lane pipelined restoring divider, q = (m*2^NW + L) / (2L).
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_div #(
    parameter int NW  = 16,
    parameter int SBW = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [2:0][tun_pkg::RED_BITS-1:0]    i_m,
    input  logic [tun_pkg::ROOT_BITS-1:0]        i_len,
    input  logic [SBW-1:0]                       i_sb,
    output logic                                 o_valid,
    output logic [2:0][NW-1:0]                   o_q,
    output logic [SBW-1:0]                       o_sb
);
    import tun_pkg::*;
    localparam int DW  = RED_BITS + NW + 1;
    localparam int DNW = ROOT_BITS + 1;
    localparam int RW  = DNW + 1;

    logic [NW:0]                         r_v;
    logic [NW:0][2:0][RW-1:0]            r_rem;
    logic [NW:0][2:0][NW-1:0]            r_low;
    logic [NW:0][2:0][NW-1:0]            r_q;
    logic [NW:0][DNW-1:0]                r_den;
    logic [NW:0][SBW-1:0]                r_sb;
    logic [2:0][DW-1:0]                  dvd;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dvd[k] = {1'b0, i_m[k], {NW{1'b0}}} + DW'(i_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NW-1:0], i_valid};
        end
    end

    // entry stage: high part of the dividend is already below 2L
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= RW'(dvd[k][DW-1:NW]);
                r_low[0][k] <= dvd[k][NW-1:0];
                r_q[0][k]   <= '0;
            end
            r_den[0] <= {i_len, 1'b0};
            r_sb[0]  <= i_sb;
        end
    end

    for (genvar j = 1; j <= NW; j++) begin : g_step
        logic [2:0][RW-1:0] cur;
        logic [2:0]         ge;

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                cur[k] = {r_rem[j-1][k][RW-2:0], r_low[j-1][k][NW-1]};
                ge[k]  = (cur[k] >= RW'(r_den[j-1]));
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    r_rem[j][k] <= ge[k] ? cur[k] - RW'(r_den[j-1]) : cur[k];
                    r_low[j][k] <= r_low[j-1][k] << 1;
                    r_q[j][k]   <= {r_q[j-1][k][NW-2:0], ge[k]};
                end
                r_den[j] <= r_den[j-1];
                r_sb[j]  <= r_sb[j-1];
            end
        end
    end

    assign o_valid = r_v[NW];
    assign o_q     = r_q[NW];
    assign o_sb    = r_sb[NW];
endmodule

>>> rtl/triangle_unit_normal.sv
// Throughput: one item per cycle while the output is not stalled; the whole pipeline advances together.
// Stall: when the output item waits, every stage holds; input ready is low then.
// Stages: 3 cross product, 5 reduction/squares, 32 square root bits,
// NORMAL_WIDTH + 1 divider, 1 output register.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
`timescale 1ns / 1ps
module triangle_unit_normal #(
    parameter int COORD_WIDTH  = 32,
    parameter int NORMAL_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tun_in_if.sink    i_tri,
    tun_out_if.source o_nrm
);
    import tun_pkg::*;
    localparam int W   = COORD_WIDTH;
    localparam int NW  = NORMAL_WIDTH;
    localparam int SBW = 3 * RED_BITS + 4;   // {deg, neg[2:0], m[2:0]}

    // global advance: the output register is free or being emptied
    logic en;

    logic                   cr_valid;
    logic signed [2*W+1:0]  cr_nx, cr_ny, cr_nz;

    logic                         rd_valid;
    logic [SUM_BITS-1:0]          rd_sum;
    logic [2:0][RED_BITS-1:0]     rd_m;
    logic [2:0]                   rd_neg;
    logic                         rd_deg;

    logic                   sq_valid;
    logic [ROOT_BITS-1:0]   sq_root;
    logic [SBW-1:0]         sq_sb;

    logic                   dv_valid;
    logic [2:0][NW-1:0]     dv_q;
    logic [3:0]             dv_sb;

    logic                   r_out_v;
    logic [2:0][NW-1:0]     r_nrm, n_nrm;
    logic                   r_deg;

    assign en          = !r_out_v || o_nrm.ready;
    assign i_tri.ready = en;

    tun_cross #(.W(W)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_tri.valid),
        .i_a_x   (i_tri.a_x), .i_a_y (i_tri.a_y), .i_a_z (i_tri.a_z),
        .i_b_x   (i_tri.b_x), .i_b_y (i_tri.b_y), .i_b_z (i_tri.b_z),
        .i_c_x   (i_tri.c_x), .i_c_y (i_tri.c_y), .i_c_z (i_tri.c_z),
        .o_valid (cr_valid),
        .o_n_x   (cr_nx),
        .o_n_y   (cr_ny),
        .o_n_z   (cr_nz)
    );

    tun_reduce #(.W(W)) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cr_valid),
        .i_n_x   (cr_nx),
        .i_n_y   (cr_ny),
        .i_n_z   (cr_nz),
        .o_valid (rd_valid),
        .o_sum   (rd_sum),
        .o_m     (rd_m),
        .o_neg   (rd_neg),
        .o_deg   (rd_deg)
    );

    // sideband rides along with the root computation
    tun_sqrt #(.SBW(SBW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rd_valid),
        .i_x     (rd_sum),
        .i_sb    ({rd_deg, rd_neg, rd_m}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_sb    (sq_sb)
    );

    // a degenerate item divides by zero here; its quotient is discarded below
    tun_div #(.NW(NW), .SBW(4)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_m     (sq_sb[3*RED_BITS-1:0]),
        .i_len   (sq_root),
        .i_sb    (sq_sb[SBW-1 -: 4]),
        .o_valid (dv_valid),
        .o_q     (dv_q),
        .o_sb    (dv_sb)
    );

    // sign, saturation of +1.0, and zeroing of degenerate triangles
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (dv_sb[3]) begin
                n_nrm[k] = '0;
            end else if (dv_sb[k]) begin
                n_nrm[k] = NW'(-dv_q[k]);
            end else if (dv_q[k][NW-1]) begin
                n_nrm[k] = {1'b0, {(NW-1){1'b1}}};
            end else begin
                n_nrm[k] = dv_q[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nrm <= n_nrm;
            r_deg <= dv_sb[3];
        end
    end

    assign o_nrm.valid      = r_out_v;
    assign o_nrm.normal_x   = r_nrm[0];
    assign o_nrm.normal_y   = r_nrm[1];
    assign o_nrm.normal_z   = r_nrm[2];
    assign o_nrm.degenerate = r_deg;

    a_deg_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nrm.valid && o_nrm.degenerate |->
            (o_nrm.normal_x == '0 && o_nrm.normal_y == '0 && o_nrm.normal_z == '0))
        else $error("degenerate item with nonzero normal");

    a_unit_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nrm.valid && !o_nrm.degenerate |->
            (o_nrm.normal_x != '0 || o_nrm.normal_y != '0 || o_nrm.normal_z != '0))
        else $error("non-degenerate item with zero normal");

    a_reset_empty : assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_nrm.valid)
        else $error("output valid right after reset");
endmodule

>>> bench/tb_triangle_unit_normal.sv
// tb_triangle_unit_normal: checks unit face normals of triangles against a built-in predictor.
// Depends on tun_pkg, tun_in_if / tun_out_if and triangle_unit_normal.
`timescale 1ns / 1ps
module tb_triangle_unit_normal;
    import tun_pkg::*;

    localparam int CW = 32;
    localparam int NW = 16;
    localparam int LATENCY = 42 + NW;

    typedef struct packed {
        logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    } tri_t;

    typedef struct packed {
        logic signed [NW-1:0] nx, ny, nz;
        logic                 degen;
    } normal_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tun_in_if  #(.COORD_WIDTH(CW))  tri_ch ();
    tun_out_if #(.NORMAL_WIDTH(NW)) nrm_ch ();

    triangle_unit_normal #(.COORD_WIDTH(CW), .NORMAL_WIDTH(NW)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tri  (tri_ch.sink),
        .o_nrm  (nrm_ch.source)
    );

    always #10 i_clk = ~i_clk;

    tri_t    pending_tris[$];
    normal_t expected_normals[$];
    int      fail_count = 0;
    bit      stim_done = 1'b0;

    // Integer square root, floor.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Exact cross product of the edges b-a and c-a, then reduce, normalize and round half up.
    function automatic normal_t face_normal(input tri_t t);
        logic signed [CW:0]   e1x, e1y, e1z, e2x, e2y, e2z;
        logic signed [67:0]   n [3];
        logic        [67:0]   mag [3];
        logic        [67:0]   mx;
        logic        [63:0]   red [3];
        logic        [63:0]   sum, len, q;
        logic        [NW-1:0] comp [3];
        normal_t r;
        int s;
        e1x = t.b_x - t.a_x; e1y = t.b_y - t.a_y; e1z = t.b_z - t.a_z;
        e2x = t.c_x - t.a_x; e2y = t.c_y - t.a_y; e2z = t.c_z - t.a_z;
        n[0] = 68'(e1y) * 68'(e2z) - 68'(e1z) * 68'(e2y);
        n[1] = 68'(e1z) * 68'(e2x) - 68'(e1x) * 68'(e2z);
        n[2] = 68'(e1x) * 68'(e2y) - 68'(e1y) * 68'(e2x);
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = n[i] < 0 ? 68'(-n[i]) : 68'(n[i]);
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) begin
            r = '0;
            r.degen = 1'b1;
            return r;
        end
        s = 0;
        while ((mx >> s) >= (68'd1 << 31)) s++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            red[i] = 64'(mag[i] >> s);
            sum = sum + red[i] * red[i];
        end
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((red[i] << NW) + len) / (2 * len);
            if (n[i] < 0 && red[i] != 0) comp[i] = NW'(-q);
            else if (q >= (64'd1 << (NW - 1))) comp[i] = NW'((64'd1 << (NW - 1)) - 1);
            else comp[i] = NW'(q);
        end
        r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2];
        r.degen = 1'b0;
        return r;
    endfunction

    function automatic logic [CW-1:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return CW'($signed($urandom_range(0, 2000)) - 1000) << 16;
            2: return $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            default: return CW'($signed($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    function automatic tri_t random_tri();
        tri_t t;
        int mode;
        mode = $urandom_range(0, 3);
        t.a_x = rand_coord(mode); t.a_y = rand_coord(mode); t.a_z = rand_coord(mode);
        t.b_x = rand_coord(mode); t.b_y = rand_coord(mode); t.b_z = rand_coord(mode);
        t.c_x = rand_coord(mode); t.c_y = rand_coord(mode); t.c_z = rand_coord(mode);
        // coincident vertices now and then (degenerate path), or a shared x coordinate
        case ($urandom_range(0, 9))
            0: t.c_x = t.a_x;
            1: begin t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z; end
            2: begin t.c_x = t.b_x; t.c_y = t.b_y; t.c_z = t.b_z; end
            default: ;
        endcase
        return t;
    endfunction

    // Stimulus: directed triangles then random ones.
    initial begin
        localparam logic [CW-1:0] ONE = 32'h0001_0000;
        localparam logic [CW-1:0] MAXC = 32'h7fff_ffff;
        localparam logic [CW-1:0] MINC = 32'h8000_0000;
        pending_tris.push_back('0);  // all coincident: degenerate
        // axis-aligned right triangles: normals +z, -z, +x, +y, +y
        pending_tris.push_back('{0, 0, 0, ONE, 0, 0, 0, ONE, 0});
        pending_tris.push_back('{0, 0, 0, 0, ONE, 0, ONE, 0, 0});
        pending_tris.push_back('{0, 0, 0, 0, ONE, 0, 0, 0, ONE});
        pending_tris.push_back('{0, 0, 0, 0, 0, ONE, ONE, 0, 0});
        pending_tris.push_back('{0, 0, 0, 0, 0, -ONE, -ONE, 0, 0});
        // collinear: degenerate
        pending_tris.push_back('{0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE});
        // extreme spans: widest edges and products
        pending_tris.push_back('{MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC});
        pending_tris.push_back('{MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MAXC});
        pending_tris.push_back('{MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MAXC, MINC});
        pending_tris.push_back('{MAXC, MINC, 0, MINC, MAXC, MINC, 0, MINC, MAXC});
        // smallest nonzero area
        pending_tris.push_back('{0, 0, 0, 1, 0, 0, 0, 1, 0});
        pending_tris.push_back('{-1, -1, -1, 0, -1, -1, -1, 0, -1});
        // equal components: rounding of 1/sqrt(3)
        pending_tris.push_back('{0, 0, 0, ONE, -ONE, 0, 0, ONE, -ONE});
        for (int i = 0; i < 1800; i++) pending_tris.push_back(random_tri());
        stim_done = 1'b1;
    end

    task automatic t_drive(input tri_t t);
        tri_ch.valid <= 1'b1;
        tri_ch.a_x <= t.a_x; tri_ch.a_y <= t.a_y; tri_ch.a_z <= t.a_z;
        tri_ch.b_x <= t.b_x; tri_ch.b_y <= t.b_y; tri_ch.b_z <= t.b_z;
        tri_ch.c_x <= t.c_x; tri_ch.c_y <= t.c_y; tri_ch.c_z <= t.c_z;
    endtask

    // input handshake as seen at the last rising edge
    bit in_taken = 1'b0;
    always @(posedge i_clk) begin
        in_taken <= tri_ch.valid && tri_ch.ready;
    end

    // Driver: bursts of random length with random gaps, changes at the falling edge.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tri_ch.valid <= 1'b0;
        end else if (tri_ch.valid && !in_taken) begin
            // item still offered, hold
        end else begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
            end
            if (gap_left > 0) begin
                gap_left--;
                tri_ch.valid <= 1'b0;
            end else if (pending_tris.size() > 0) begin
                t_drive(pending_tris.pop_front());
                burst_left--;
            end else begin
                tri_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver ready pattern, with one long hold-off to fill the pipeline.
    int cycle_count = 0;
    always @(negedge i_clk) begin
        cycle_count++;
        if (cycle_count > 600 && cycle_count <= 900)
            nrm_ch.ready <= 1'b0;
        else if ((cycle_count / 200) % 3 == 0)
            nrm_ch.ready <= 1'b1;
        else
            nrm_ch.ready <= $urandom_range(0, 3) != 0;
    end

    // Monitor: predict on accepted triangles, check accepted normals.
    always @(posedge i_clk) begin
        normal_t got, want;
        if (i_rst_n) begin
            if (tri_ch.valid && tri_ch.ready)
                expected_normals.push_back(face_normal({tri_ch.a_x, tri_ch.a_y, tri_ch.a_z,
                    tri_ch.b_x, tri_ch.b_y, tri_ch.b_z, tri_ch.c_x, tri_ch.c_y, tri_ch.c_z}));
            if (nrm_ch.valid && nrm_ch.ready) begin
                got = {nrm_ch.normal_x, nrm_ch.normal_y, nrm_ch.normal_z, nrm_ch.degenerate};
                if (expected_normals.size() == 0) begin
                    $display("%0t: unexpected normal %h", $realtime, got);
                    fail_count++;
                end else begin
                    want = expected_normals.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected x=%0d y=%0d z=%0d deg=%0b, got x=%0d y=%0d z=%0d deg=%0b",
                                 $realtime, want.nx, want.ny, want.nz, want.degen,
                                 got.nx, got.ny, got.nz, got.degen);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && pending_tris.size() == 0);
        @(negedge i_clk);
        wait (!tri_ch.valid && expected_normals.size() == 0);
        repeat (LATENCY * 2) @(posedge i_clk);
        if (fail_count == 0 && expected_normals.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
